// ----- rtl/psu_pkg.sv -----
// Shared types, codes and constants of the particle swarm update block.
// Depends on nothing; psu_mul, particle_swarm_update and psu_check refer to it by scoped names.
package psu_pkg;

   localparam int DEF_MAX_PARTICLES = 32;
   localparam int DEF_MAX_DIMS      = 8;

   localparam int POS_W  = 16;   // signed Q8.8 position, velocity and best elements
   localparam int GAIN_W = 16;   // unsigned Q4.12 gains
   localparam int RAND_W = 16;   // unsigned Q0.16 random factors
   localparam int FIT_W  = 40;   // unsigned Q24.16 fitness
   localparam int PCNT_W = 6;
   localparam int DCNT_W = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Shared multiplier: signed 34 x 18 bits, enough for gain*rand times a difference.
   localparam int MA_W = 34;
   localparam int MB_W = 18;
   localparam int MP_W = MA_W + MB_W;
   localparam int ACC_W = 54;
   localparam int RND_SHIFT = 28;

   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_UPDATE = 2'd1;
   localparam logic [1:0] KIND_COMMIT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_INERTIA   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COGNITIVE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SOCIAL    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PARTICLES = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIMS      = 3'd4;

   localparam logic [GAIN_W-1:0] INERTIA_RESET   = 16'd4096;
   localparam logic [GAIN_W-1:0] COGNITIVE_RESET = 16'd8192;
   localparam logic [GAIN_W-1:0] SOCIAL_RESET    = 16'd8192;
   localparam logic [PCNT_W-1:0] PARTICLES_RESET = 6'd32;
   localparam logic [DCNT_W-1:0] DIMS_RESET      = 4'd2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LD_WR,
      ST_FIT_RD,
      ST_FIT_MUL,
      ST_FIT_ACC,
      ST_FIT_DONE,
      ST_UP_CMP,
      ST_UP_CP_RD,
      ST_UP_CP_WR,
      ST_UP_OUT,
      ST_UP_A1,
      ST_UP_A2,
      ST_UP_A3,
      ST_UP_RD,
      ST_UP_M0,
      ST_UP_M1,
      ST_UP_M2,
      ST_UP_M3,
      ST_UP_WR,
      ST_CM_RD,
      ST_CM_CMP,
      ST_CM_CP_RD,
      ST_CM_CP_WR,
      ST_CM_OUT
   } state_type;

endpackage

// ----- rtl/psu_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// Stands alone; used for every particle store of the block.
module psu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/psu_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on psu_pkg for the operand widths.
module psu_mul (
   input  logic                              clock,
   input  logic signed [psu_pkg::MA_W-1:0]   mul_a,
   input  logic signed [psu_pkg::MB_W-1:0]   mul_b,
   output logic signed [psu_pkg::MP_W-1:0]   prod
);

   logic signed [psu_pkg::MP_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign prod = prod_ff;

endmodule

// ----- rtl/particle_swarm_update.sv -----
// Particle swarm update block. A sequencer drives one 34x18 multiplier and
// single-read-port stores, so one word is in work at a time and req_stall
// stays high until it is finished. With D coordinates and P particles in use:
// a load writes one coordinate and its fitness, an update also renews D
// velocities and positions and copies them on a new personal best, and a
// commit scans P particles, copying D coordinates per new global best, then
// D result words. Each coordinate costs four multiplier passes (three for the
// velocity, one for its square) plus two store reads. Result words sit in an
// output register, so rsp_stall only delays the sequencer when a further word
// is ready. Stores are not cleared at reset: an update or commit must only
// touch fully loaded particles. Depends on psu_pkg, psu_ram and psu_mul.
module particle_swarm_update #(
   parameter int MAX_PARTICLES = psu_pkg::DEF_MAX_PARTICLES,
   parameter int MAX_DIMS      = psu_pkg::DEF_MAX_DIMS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [psu_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [psu_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_kind,
   input  logic [4:0]                           req_particle,
   input  logic [2:0]                           req_coord,
   input  logic signed [psu_pkg::POS_W-1:0]     req_value,
   input  logic [psu_pkg::RAND_W-1:0]           req_rand_cognitive,
   input  logic [psu_pkg::RAND_W-1:0]           req_rand_social,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [psu_pkg::FIT_W-1:0]            rsp_fitness,
   output logic                                 rsp_improved,
   output logic [2:0]                           rsp_out_coord,
   output logic signed [psu_pkg::POS_W-1:0]     rsp_best_value,
   output logic                                 rsp_last
);

   localparam int P_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int K_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int DEPTH = MAX_PARTICLES * MAX_DIMS;
   localparam int A_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int POS_W = psu_pkg::POS_W;
   localparam int FIT_W = psu_pkg::FIT_W;
   localparam int ACC_W = psu_pkg::ACC_W;

   psu_pkg::state_type state_ff, state_in;

   logic [psu_pkg::GAIN_W-1:0] inertia_ff, cognitive_ff, social_ff;
   logic [psu_pkg::PCNT_W-1:0] pcount_ff;
   logic [psu_pkg::DCNT_W-1:0] dcount_ff;

   logic                        is_update_ff, is_update_in;
   logic [P_W-1:0]              j_ff, j_in;
   logic [K_W-1:0]              c_ff, c_in;
   logic signed [POS_W-1:0]     val_ff, val_in;
   logic [psu_pkg::RAND_W-1:0]  r1_ff, r1_in, r2_ff, r2_in;
   logic [K_W-1:0]              k_ff, k_in;
   logic [P_W-1:0]              i_ff, i_in;
   logic [31:0]                 a1_ff, a1_in, a2_ff, a2_in;
   logic signed [ACC_W-1:0]     accv_ff, accv_in;
   logic [FIT_W-1:0]            fit_ff, fit_in;
   logic                        imp_ff, imp_in;
   logic [FIT_W-1:0]            bestfit_ff, bestfit_in;
   logic signed [POS_W-1:0]     bestpos_ff [MAX_DIMS];
   logic                        bestpos_we;

   logic                        rsp_valid_ff;
   logic [FIT_W-1:0]            rsp_fitness_ff;
   logic                        rsp_improved_ff;
   logic [2:0]                  rsp_out_coord_ff;
   logic signed [POS_W-1:0]     rsp_best_value_ff;
   logic                        rsp_last_ff;
   logic                        push;
   logic [FIT_W-1:0]            push_fitness;
   logic                        push_improved;
   logic [2:0]                  push_coord;
   logic signed [POS_W-1:0]     push_value;
   logic                        push_last;

   logic                        accept, out_free;
   logic [P_W-1:0]              p_last;
   logic [K_W-1:0]              d_last;
   logic                        k_done;
   logic [A_W-1:0]              addr_jk, addr_jc, addr_ik;

   logic                        pos_we, pos_re, vel_we, vel_re, pb_we, pb_re;
   logic [A_W-1:0]              pos_waddr, pos_raddr, rd_addr;
   logic [POS_W-1:0]            pos_wdata, vel_wdata, pb_wdata;
   logic [POS_W-1:0]            pos_rdata_u, vel_rdata_u, pb_rdata_u;
   logic signed [POS_W-1:0]     pos_rd, vel_rd, pb_rd;
   logic                        fit_we, fit_re, pbf_we, pbf_re;
   logic [P_W-1:0]              fit_waddr;
   logic [FIT_W-1:0]            fit_rdata, pbf_rdata;

   logic signed [psu_pkg::MA_W-1:0] mul_a;
   logic signed [psu_pkg::MB_W-1:0] mul_b;
   logic signed [psu_pkg::MP_W-1:0] prod;

   logic signed [POS_W:0]       d1, d2, psum;
   logic signed [ACC_W-1:0]     rsum, rq;
   logic signed [POS_W-1:0]     nv, npos;

   // Counts in use, clamped to the built sizes, held as their last index.
   always_comb begin
      if (pcount_ff == '0) begin
         p_last = '0;
      end else if (32'(pcount_ff) > MAX_PARTICLES) begin
         p_last = P_W'(MAX_PARTICLES - 1);
      end else begin
         p_last = P_W'(pcount_ff - 1'b1);
      end
      if (dcount_ff == '0) begin
         d_last = '0;
      end else if (32'(dcount_ff) > MAX_DIMS) begin
         d_last = K_W'(MAX_DIMS - 1);
      end else begin
         d_last = K_W'(dcount_ff - 1'b1);
      end
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != psu_pkg::ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign k_done    = (k_ff == d_last);

   assign addr_jk = A_W'(32'(j_ff) * MAX_DIMS + 32'(k_ff));
   assign addr_jc = A_W'(32'(j_ff) * MAX_DIMS + 32'(c_ff));
   assign addr_ik = A_W'(32'(i_ff) * MAX_DIMS + 32'(k_ff));

   assign pos_rd = pos_rdata_u;
   assign vel_rd = vel_rdata_u;
   assign pb_rd  = pb_rdata_u;

   // Velocity arithmetic: differences, rounding to Q8.8 and saturation.
   always_comb begin
      d1   = (POS_W+1)'(pb_rd) - (POS_W+1)'(pos_rd);
      d2   = (POS_W+1)'(bestpos_ff[k_ff]) - (POS_W+1)'(pos_rd);
      rsum = accv_ff + (ACC_W'(1) <<< (psu_pkg::RND_SHIFT - 1));
      rq   = rsum >>> psu_pkg::RND_SHIFT;
      if (rq > ACC_W'(32767)) begin
         nv = 16'sh7FFF;
      end else if (rq < -ACC_W'(32768)) begin
         nv = 16'sh8000;
      end else begin
         nv = POS_W'(rq);
      end
      psum = (POS_W+1)'(pos_rd) + (POS_W+1)'(nv);
      if (psum > 17'sd32767) begin
         npos = 16'sh7FFF;
      end else if (psum < -17'sd32768) begin
         npos = 16'sh8000;
      end else begin
         npos = POS_W'(psum);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psu_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  psu_pkg::KIND_LOAD: begin
                     if (32'(req_particle) <= 32'(p_last) && 32'(req_coord) <= 32'(d_last)) begin
                        state_in = psu_pkg::ST_LD_WR;
                     end
                  end
                  psu_pkg::KIND_UPDATE: begin
                     if (32'(req_particle) <= 32'(p_last)) begin
                        state_in = psu_pkg::ST_UP_A1;
                     end
                  end
                  psu_pkg::KIND_COMMIT: state_in = psu_pkg::ST_CM_RD;
                  default: state_in = psu_pkg::ST_IDLE;
               endcase
            end
         end
         psu_pkg::ST_LD_WR:    state_in = psu_pkg::ST_FIT_RD;
         psu_pkg::ST_FIT_RD:   state_in = psu_pkg::ST_FIT_MUL;
         psu_pkg::ST_FIT_MUL:  state_in = psu_pkg::ST_FIT_ACC;
         psu_pkg::ST_FIT_ACC:  state_in = k_done ? psu_pkg::ST_FIT_DONE : psu_pkg::ST_FIT_RD;
         psu_pkg::ST_FIT_DONE: state_in = is_update_ff ? psu_pkg::ST_UP_CMP : psu_pkg::ST_IDLE;
         psu_pkg::ST_UP_CMP: begin
            state_in = (fit_ff < pbf_rdata) ? psu_pkg::ST_UP_CP_RD : psu_pkg::ST_UP_OUT;
         end
         psu_pkg::ST_UP_CP_RD: state_in = psu_pkg::ST_UP_CP_WR;
         psu_pkg::ST_UP_CP_WR: state_in = k_done ? psu_pkg::ST_UP_OUT : psu_pkg::ST_UP_CP_RD;
         psu_pkg::ST_UP_OUT:   state_in = out_free ? psu_pkg::ST_IDLE : psu_pkg::ST_UP_OUT;
         psu_pkg::ST_UP_A1:    state_in = psu_pkg::ST_UP_A2;
         psu_pkg::ST_UP_A2:    state_in = psu_pkg::ST_UP_A3;
         psu_pkg::ST_UP_A3:    state_in = psu_pkg::ST_UP_RD;
         psu_pkg::ST_UP_RD:    state_in = psu_pkg::ST_UP_M0;
         psu_pkg::ST_UP_M0:    state_in = psu_pkg::ST_UP_M1;
         psu_pkg::ST_UP_M1:    state_in = psu_pkg::ST_UP_M2;
         psu_pkg::ST_UP_M2:    state_in = psu_pkg::ST_UP_M3;
         psu_pkg::ST_UP_M3:    state_in = psu_pkg::ST_UP_WR;
         psu_pkg::ST_UP_WR:    state_in = k_done ? psu_pkg::ST_FIT_RD : psu_pkg::ST_UP_RD;
         psu_pkg::ST_CM_RD:    state_in = psu_pkg::ST_CM_CMP;
         psu_pkg::ST_CM_CMP: begin
            if (fit_rdata < bestfit_ff) begin
               state_in = psu_pkg::ST_CM_CP_RD;
            end else begin
               state_in = (i_ff == p_last) ? psu_pkg::ST_CM_OUT : psu_pkg::ST_CM_RD;
            end
         end
         psu_pkg::ST_CM_CP_RD: state_in = psu_pkg::ST_CM_CP_WR;
         psu_pkg::ST_CM_CP_WR: begin
            if (!k_done) begin
               state_in = psu_pkg::ST_CM_CP_RD;
            end else begin
               state_in = (i_ff == p_last) ? psu_pkg::ST_CM_OUT : psu_pkg::ST_CM_RD;
            end
         end
         psu_pkg::ST_CM_OUT: begin
            if (out_free && k_done) begin
               state_in = psu_pkg::ST_IDLE;
            end
         end
         default: state_in = psu_pkg::ST_IDLE;
      endcase
   end

   // Datapath control and register next values.
   always_comb begin
      is_update_in = is_update_ff;
      j_in = j_ff;
      c_in = c_ff;
      val_in = val_ff;
      r1_in = r1_ff;
      r2_in = r2_ff;
      k_in = k_ff;
      i_in = i_ff;
      a1_in = a1_ff;
      a2_in = a2_ff;
      accv_in = accv_ff;
      fit_in = fit_ff;
      imp_in = imp_ff;
      bestfit_in = bestfit_ff;
      bestpos_we = 1'b0;
      pos_we = 1'b0;
      pos_waddr = addr_jk;
      pos_wdata = npos;
      vel_we = 1'b0;
      vel_wdata = nv;
      pb_we = 1'b0;
      pb_wdata = pos_rd;
      pos_re = 1'b0;
      vel_re = 1'b0;
      pb_re = 1'b0;
      rd_addr = addr_jk;
      fit_we = 1'b0;
      fit_waddr = j_ff;
      fit_re = 1'b0;
      pbf_we = 1'b0;
      pbf_re = 1'b0;
      mul_a = psu_pkg::MA_W'(pos_rd);
      mul_b = psu_pkg::MB_W'(pos_rd);
      push = 1'b0;
      push_fitness = fit_ff;
      push_improved = imp_ff;
      push_coord = '0;
      push_value = '0;
      push_last = 1'b1;
      unique case (state_ff)
         psu_pkg::ST_IDLE: begin
            if (accept) begin
               is_update_in = (req_kind == psu_pkg::KIND_UPDATE);
               j_in = P_W'(req_particle);
               c_in = K_W'(req_coord);
               val_in = req_value;
               r1_in = req_rand_cognitive;
               r2_in = req_rand_social;
               k_in = '0;
               i_in = '0;
               imp_in = 1'b0;
               fit_in = '0;
            end
         end
         psu_pkg::ST_LD_WR: begin
            pos_we = 1'b1;
            pos_waddr = addr_jc;
            pos_wdata = val_ff;
            vel_we = 1'b1;
            vel_wdata = '0;
            pb_we = 1'b1;
            pb_wdata = val_ff;
         end
         psu_pkg::ST_FIT_RD: begin
            pos_re = 1'b1;
         end
         psu_pkg::ST_FIT_MUL: begin
            mul_a = psu_pkg::MA_W'(pos_rd);
            mul_b = psu_pkg::MB_W'(pos_rd);
         end
         psu_pkg::ST_FIT_ACC: begin
            fit_in = fit_ff + FIT_W'(prod);
            k_in = k_done ? '0 : k_ff + 1'b1;
         end
         psu_pkg::ST_FIT_DONE: begin
            fit_we = 1'b1;
            pbf_we = !is_update_ff;
            pbf_re = is_update_ff;
         end
         psu_pkg::ST_UP_CMP: begin
            if (fit_ff < pbf_rdata) begin
               imp_in = 1'b1;
               pbf_we = 1'b1;
            end
         end
         psu_pkg::ST_UP_CP_RD: begin
            pos_re = 1'b1;
         end
         psu_pkg::ST_UP_CP_WR: begin
            pb_we = 1'b1;
            pb_wdata = pos_rd;
            k_in = k_done ? '0 : k_ff + 1'b1;
         end
         psu_pkg::ST_UP_OUT: begin
            push = out_free;
         end
         psu_pkg::ST_UP_A1: begin
            mul_a = psu_pkg::MA_W'({1'b0, cognitive_ff});
            mul_b = psu_pkg::MB_W'({1'b0, r1_ff});
         end
         psu_pkg::ST_UP_A2: begin
            a1_in = 32'(prod);
            mul_a = psu_pkg::MA_W'({1'b0, social_ff});
            mul_b = psu_pkg::MB_W'({1'b0, r2_ff});
         end
         psu_pkg::ST_UP_A3: begin
            a2_in = 32'(prod);
            k_in = '0;
         end
         psu_pkg::ST_UP_RD: begin
            pos_re = 1'b1;
            vel_re = 1'b1;
            pb_re = 1'b1;
         end
         psu_pkg::ST_UP_M0: begin
            mul_a = psu_pkg::MA_W'({1'b0, inertia_ff});
            mul_b = psu_pkg::MB_W'(vel_rd);
         end
         psu_pkg::ST_UP_M1: begin
            // w*v carries sixteen fraction bits fewer than the gain terms.
            accv_in = ACC_W'(prod) <<< 16;
            mul_a = psu_pkg::MA_W'({1'b0, a1_ff});
            mul_b = psu_pkg::MB_W'(d1);
         end
         psu_pkg::ST_UP_M2: begin
            accv_in = accv_ff + ACC_W'(prod);
            mul_a = psu_pkg::MA_W'({1'b0, a2_ff});
            mul_b = psu_pkg::MB_W'(d2);
         end
         psu_pkg::ST_UP_M3: begin
            accv_in = accv_ff + ACC_W'(prod);
         end
         psu_pkg::ST_UP_WR: begin
            pos_we = 1'b1;
            vel_we = 1'b1;
            k_in = k_done ? '0 : k_ff + 1'b1;
            if (k_done) begin
               fit_in = '0;
            end
         end
         psu_pkg::ST_CM_RD: begin
            fit_re = 1'b1;
         end
         psu_pkg::ST_CM_CMP: begin
            k_in = '0;
            if (fit_rdata < bestfit_ff) begin
               bestfit_in = fit_rdata;
               imp_in = 1'b1;
            end else if (i_ff != p_last) begin
               i_in = i_ff + 1'b1;
            end
         end
         psu_pkg::ST_CM_CP_RD: begin
            rd_addr = addr_ik;
            pos_re = 1'b1;
         end
         psu_pkg::ST_CM_CP_WR: begin
            bestpos_we = 1'b1;
            if (k_done) begin
               k_in = '0;
               if (i_ff != p_last) begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         psu_pkg::ST_CM_OUT: begin
            push = out_free;
            push_fitness = bestfit_ff;
            push_coord = 3'(k_ff);
            push_value = bestpos_ff[k_ff];
            push_last = k_done;
            if (out_free && !k_done) begin
               k_in = k_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psu_pkg::ST_IDLE;
         inertia_ff <= psu_pkg::INERTIA_RESET;
         cognitive_ff <= psu_pkg::COGNITIVE_RESET;
         social_ff <= psu_pkg::SOCIAL_RESET;
         pcount_ff <= psu_pkg::PARTICLES_RESET;
         dcount_ff <= psu_pkg::DIMS_RESET;
         bestfit_ff <= '1;
         for (int n = 0; n < MAX_DIMS; n++) begin
            bestpos_ff[n] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         bestfit_ff <= bestfit_in;
         if (bestpos_we) begin
            bestpos_ff[k_ff] <= pos_rd;
         end
         if (csr_write) begin
            unique case (csr_index)
               psu_pkg::CSR_INERTIA:   inertia_ff <= csr_wdata;
               psu_pkg::CSR_COGNITIVE: cognitive_ff <= csr_wdata;
               psu_pkg::CSR_SOCIAL:    social_ff <= csr_wdata;
               psu_pkg::CSR_PARTICLES: pcount_ff <= csr_wdata[psu_pkg::PCNT_W-1:0];
               psu_pkg::CSR_DIMS:      dcount_ff <= csr_wdata[psu_pkg::DCNT_W-1:0];
               default: begin
               end
            endcase
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      is_update_ff <= is_update_in;
      j_ff <= j_in;
      c_ff <= c_in;
      val_ff <= val_in;
      r1_ff <= r1_in;
      r2_ff <= r2_in;
      k_ff <= k_in;
      i_ff <= i_in;
      a1_ff <= a1_in;
      a2_ff <= a2_in;
      accv_ff <= accv_in;
      fit_ff <= fit_in;
      imp_ff <= imp_in;
      if (push) begin
         rsp_fitness_ff <= push_fitness;
         rsp_improved_ff <= push_improved;
         rsp_out_coord_ff <= push_coord;
         rsp_best_value_ff <= push_value;
         rsp_last_ff <= push_last;
      end
   end

   assign pos_raddr = rd_addr;

   psu_ram #(.WIDTH(POS_W), .DEPTH(DEPTH)) u_pos_ram (
      .clock(clock), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
      .re(pos_re), .raddr(pos_raddr), .rdata(pos_rdata_u)
   );

   psu_ram #(.WIDTH(POS_W), .DEPTH(DEPTH)) u_vel_ram (
      .clock(clock), .we(vel_we), .waddr(pos_waddr), .wdata(vel_wdata),
      .re(vel_re), .raddr(addr_jk), .rdata(vel_rdata_u)
   );

   psu_ram #(.WIDTH(POS_W), .DEPTH(DEPTH)) u_pb_ram (
      .clock(clock), .we(pb_we), .waddr(pos_waddr), .wdata(pb_wdata),
      .re(pb_re), .raddr(addr_jk), .rdata(pb_rdata_u)
   );

   psu_ram #(.WIDTH(FIT_W), .DEPTH(MAX_PARTICLES)) u_fit_ram (
      .clock(clock), .we(fit_we), .waddr(fit_waddr), .wdata(fit_ff),
      .re(fit_re), .raddr(i_ff), .rdata(fit_rdata)
   );

   psu_ram #(.WIDTH(FIT_W), .DEPTH(MAX_PARTICLES)) u_pbf_ram (
      .clock(clock), .we(pbf_we), .waddr(fit_waddr), .wdata(fit_ff),
      .re(pbf_re), .raddr(j_ff), .rdata(pbf_rdata)
   );

   psu_mul u_mul (
      .clock(clock), .mul_a(mul_a), .mul_b(mul_b), .prod(prod)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fitness    = rsp_fitness_ff;
   assign rsp_improved   = rsp_improved_ff;
   assign rsp_out_coord  = rsp_out_coord_ff;
   assign rsp_best_value = rsp_best_value_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ----- rtl/psu_check.sv -----
// Port-level checks for particle_swarm_update, attached by the bind below.
// Depends on psu_pkg for the item kind codes.
module psu_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_kind,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [39:0] rsp_fitness,
   input logic [15:0] rsp_best_value,
   input logic        rsp_last
);

   // A stalled result word stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   // Its payload does not move while stalled.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_fitness) && $stable(rsp_best_value))
      else $error("result payload changed while stalled");

   // A commit always keeps the block busy for at least the next cycle.
   a_commit_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind == psu_pkg::KIND_COMMIT |=> req_stall)
      else $error("commit word did not occupy the block");

   // While a word that is not the last of its stream is offered, the block stays busy.
   a_stream_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("new word accepted in the middle of a result stream");

endmodule

bind particle_swarm_update psu_check u_psu_check (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_kind(req_kind),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_fitness(rsp_fitness),
   .rsp_best_value(rsp_best_value),
   .rsp_last(rsp_last)
);
